// ===== rtl/ghht_pkg.sv =====
// shared types, widths and register indexes of the group hadamard hard threshold block
`default_nettype none
package ghht_pkg;

	// largest group the block supports
	localparam int GROUP_MAX = 8;
	localparam int NLANE     = 8;
	localparam int LOG2_LANE = 3;
	localparam int LOG2_MAX  = (GROUP_MAX >= 8) ? 3 : (GROUP_MAX >= 4) ? 2 :
	                           (GROUP_MAX >= 2) ? 1 : 0;

	// data widths
	localparam int DATA_W = 24;
	localparam int SUM_W  = 31;
	localparam int MAG_W  = 27;
	localparam int SQ_W   = 2 * MAG_W;
	localparam int THR_W  = 48;
	localparam int LIM_W  = THR_W + LOG2_LANE;
	localparam int LG_W   = 2;
	localparam int CNT_W  = 4;
	localparam int IDX_W  = 1;

	// register indexes
	localparam logic [IDX_W-1:0] REG_GROUP_LOG2 = 1'b0;
	localparam logic [IDX_W-1:0] REG_THRESHOLD  = 1'b1;

	localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic signed [SUM_W-1:0]  sum_t;
	typedef sum_t                     sum_arr_t [NLANE];
	typedef logic [LIM_W-1:0]         limit_t;

	// control that travels with a word down the pipeline
	typedef struct packed {
		logic            vld;
		logic            dc;
		logic [LG_W-1:0] lg;
	} ctl_t;

endpackage
`default_nettype wire

// ===== rtl/ghht_fwht.sv =====
// unnormalized walsh-hadamard butterfly network over the active group length
`default_nettype none
module ghht_fwht (
	input  ghht_pkg::sum_arr_t        din,
	input  logic [ghht_pkg::LG_W-1:0] lg,
	output ghht_pkg::sum_arr_t        dout
);

	// one butterfly rank per doubling of the span, ranks beyond the group are bypassed
	always_comb begin
		ghht_pkg::sum_arr_t v;
		ghht_pkg::sum_t     a;
		ghht_pkg::sum_t     b;
		v = din;
		a = '0;
		b = '0;
		for (int s = 0; s < ghht_pkg::LOG2_LANE; s++) begin
			if (s < int'(lg)) begin
				for (int j = 0; j < ghht_pkg::NLANE; j++) begin
					if ((j & (1 << s)) == 0) begin
						a = v[j];
						b = v[j + (1 << s)];
						v[j] = a + b;
						v[j + (1 << s)] = a - b;
					end
				end
			end
		end
		dout = v;
	end

endmodule
`default_nettype wire

// ===== rtl/ghht_lane.sv =====
// one lane: squares a transformed value and zeroes it when below the limit, unless it is exempt
`default_nettype none
module ghht_lane (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ghht_pkg::sum_t        val,
	input  ghht_pkg::limit_t      limit,
	input  logic                  exempt,
	input  logic                  active,
	output ghht_pkg::sum_t        y,
	output logic                  keep
);

	logic [ghht_pkg::SUM_W-1:0] mag_full;
	logic [ghht_pkg::MAG_W-1:0] mag;
	logic [ghht_pkg::SQ_W-1:0]  sq_s3;
	ghht_pkg::sum_t             val_s3;
	ghht_pkg::limit_t           limit_s3;
	logic                       exempt_s3;
	logic                       active_s3;
	logic                       keep_c;

	// magnitude of the transformed value
	assign mag_full = val[ghht_pkg::SUM_W-1] ? ghht_pkg::SUM_W'(-val) : ghht_pkg::SUM_W'(val);
	assign mag      = mag_full[ghht_pkg::MAG_W-1:0];

	// square stage
	always_ff @(posedge clk) begin
		sq_s3     <= mag * mag;
		val_s3    <= val;
		limit_s3  <= limit;
		exempt_s3 <= exempt;
		active_s3 <= active;
	end

	// hard threshold decision
	assign keep_c = exempt_s3 ||
	                (sq_s3 >= {{(ghht_pkg::SQ_W - ghht_pkg::LIM_W){1'b0}}, limit_s3});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep <= 1'b0;
		end else begin
			keep <= keep_c && active_s3;
		end
	end

	always_ff @(posedge clk) begin
		y <= keep_c ? val_s3 : '0;
	end

endmodule
`default_nettype wire

// ===== rtl/ghht_merge.sv =====
// merges the lanes: inverse transform, kept count, rounding and saturation
`default_nettype none
module ghht_merge (
	input  logic                         clk,
	input  logic                         arst_n,
	input  ghht_pkg::ctl_t               ctl,
	input  ghht_pkg::sum_arr_t           y,
	input  logic [ghht_pkg::NLANE-1:0]   keep,
	output logic                         done,
	output ghht_pkg::data_t              est [ghht_pkg::NLANE],
	output logic [ghht_pkg::CNT_W-1:0]   kept_count
);

	ghht_pkg::sum_arr_t          inv;
	ghht_pkg::sum_arr_t          r_s5;
	ghht_pkg::ctl_t              ctl_s5;
	logic [ghht_pkg::CNT_W-1:0]  cnt_s5;
	logic [ghht_pkg::SUM_W:0]    half;

	ghht_fwht u_inv (
		.din  (y),
		.lg   (ctl.lg),
		.dout (inv)
	);

	// inverse transform and kept count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5 <= '0;
		end else begin
			ctl_s5 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		r_s5   <= inv;
		cnt_s5 <= ghht_pkg::CNT_W'($countones(keep));
	end

	// half of the group length, the rounding offset
	assign half = (ghht_pkg::SUM_W + 1)'((ghht_pkg::SUM_W + 1)'(1) << ctl_s5.lg) >> 1;

	// divide by the group length with rounding to nearest, then clamp
	always_ff @(posedge clk) begin
		for (int j = 0; j < ghht_pkg::NLANE; j++) begin
			logic signed [ghht_pkg::SUM_W:0] t;
			t = (signed'({r_s5[j][ghht_pkg::SUM_W-1], r_s5[j]}) + signed'(half)) >>>
			    ctl_s5.lg;
			if (t > (ghht_pkg::SUM_W + 1)'(ghht_pkg::DATA_MAX)) begin
				est[j] <= ghht_pkg::DATA_MAX;
			end else if (t < (ghht_pkg::SUM_W + 1)'(ghht_pkg::DATA_MIN)) begin
				est[j] <= ghht_pkg::DATA_MIN;
			end else begin
				est[j] <= t[ghht_pkg::DATA_W-1:0];
			end
		end
		kept_count <= cnt_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= ctl_s5.vld;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/group_hadamard_hard_threshold.sv =====
// top level: group hadamard transform, hard threshold and inverse over eight lanes
//
// One word is taken on every clock cycle (busy never rises) and its result appears on
// the est and kept_count ports for one cycle, marked by done. Each word passes through
// the pipeline: input register, forward butterflies, lane square, threshold decision,
// inverse butterflies, rounding and clamp. The receiver cannot stall the block.
// Configuration writes are taken at once and must happen only while no word is in
// flight.
`default_nettype none
module group_hadamard_hard_threshold (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          wr_en,
	input  logic [ghht_pkg::IDX_W-1:0]    wr_index,
	input  logic [ghht_pkg::THR_W-1:0]    wr_data,
	input  logic signed [ghht_pkg::DATA_W-1:0] coef_0,
	input  logic signed [ghht_pkg::DATA_W-1:0] coef_1,
	input  logic signed [ghht_pkg::DATA_W-1:0] coef_2,
	input  logic signed [ghht_pkg::DATA_W-1:0] coef_3,
	input  logic signed [ghht_pkg::DATA_W-1:0] coef_4,
	input  logic signed [ghht_pkg::DATA_W-1:0] coef_5,
	input  logic signed [ghht_pkg::DATA_W-1:0] coef_6,
	input  logic signed [ghht_pkg::DATA_W-1:0] coef_7,
	input  logic                          dc_position,
	output logic                          done,
	output logic signed [ghht_pkg::DATA_W-1:0] est_0,
	output logic signed [ghht_pkg::DATA_W-1:0] est_1,
	output logic signed [ghht_pkg::DATA_W-1:0] est_2,
	output logic signed [ghht_pkg::DATA_W-1:0] est_3,
	output logic signed [ghht_pkg::DATA_W-1:0] est_4,
	output logic signed [ghht_pkg::DATA_W-1:0] est_5,
	output logic signed [ghht_pkg::DATA_W-1:0] est_6,
	output logic signed [ghht_pkg::DATA_W-1:0] est_7,
	output logic [ghht_pkg::CNT_W-1:0]    kept_count
);

	logic [ghht_pkg::LG_W-1:0]   group_log2_q;
	logic [ghht_pkg::THR_W-1:0]  threshold_q;
	logic [ghht_pkg::LG_W-1:0]   lg_eff;
	ghht_pkg::data_t             cin [ghht_pkg::NLANE];
	ghht_pkg::sum_arr_t          x_s1;
	ghht_pkg::sum_arr_t          fwd;
	ghht_pkg::sum_arr_t          v_s2;
	ghht_pkg::sum_arr_t          y_s4;
	ghht_pkg::limit_t            limit_s1;
	ghht_pkg::limit_t            limit_s2;
	ghht_pkg::ctl_t              ctl_s1;
	ghht_pkg::ctl_t              ctl_s2;
	ghht_pkg::ctl_t              ctl_s3;
	ghht_pkg::ctl_t              ctl_s4;
	logic [ghht_pkg::NLANE-1:0]  keep_s4;
	ghht_pkg::data_t             est [ghht_pkg::NLANE];

	assign busy = 1'b0;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_log2_q <= ghht_pkg::LG_W'(3);
			threshold_q  <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				ghht_pkg::REG_GROUP_LOG2: group_log2_q <= wr_data[ghht_pkg::LG_W-1:0];
				ghht_pkg::REG_THRESHOLD:  threshold_q  <= wr_data;
				default: ;
			endcase
		end
	end

	// group length limited to what the block supports
	assign lg_eff = (int'(group_log2_q) > ghht_pkg::LOG2_MAX) ?
	                ghht_pkg::LG_W'(ghht_pkg::LOG2_MAX) : group_log2_q;

	assign cin[0] = coef_0;
	assign cin[1] = coef_1;
	assign cin[2] = coef_2;
	assign cin[3] = coef_3;
	assign cin[4] = coef_4;
	assign cin[5] = coef_5;
	assign cin[6] = coef_6;
	assign cin[7] = coef_7;

	// control pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			ctl_s1 <= '{vld: start && !busy, dc: dc_position, lg: lg_eff};
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	// input register, members beyond the group length read as zero
	always_ff @(posedge clk) begin
		for (int j = 0; j < ghht_pkg::NLANE; j++) begin
			x_s1[j] <= (j < (1 << lg_eff)) ? ghht_pkg::SUM_W'(cin[j]) : '0;
		end
		limit_s1 <= ghht_pkg::limit_t'(ghht_pkg::limit_t'(threshold_q) << lg_eff);
	end

	// forward transform
	ghht_fwht u_fwd (
		.din  (x_s1),
		.lg   (ctl_s1.lg),
		.dout (fwd)
	);

	always_ff @(posedge clk) begin
		v_s2     <= fwd;
		limit_s2 <= limit_s1;
	end

	// threshold lanes
	for (genvar g = 0; g < ghht_pkg::NLANE; g++) begin : g_lane
		ghht_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.val    (v_s2[g]),
			.limit  (limit_s2),
			.exempt ((g == 0) && ctl_s2.dc),
			.active (g < (1 << ctl_s2.lg)),
			.y      (y_s4[g]),
			.keep   (keep_s4[g])
		);
	end

	// merge stage
	ghht_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl_s4),
		.y          (y_s4),
		.keep       (keep_s4),
		.done       (done),
		.est        (est),
		.kept_count (kept_count)
	);

	assign est_0 = est[0];
	assign est_1 = est[1];
	assign est_2 = est[2];
	assign est_3 = est[3];
	assign est_4 = est[4];
	assign est_5 = est[5];
	assign est_6 = est[6];
	assign est_7 = est[7];

endmodule
`default_nettype wire
